>>> sv/rcm_pkg.sv
// shared types, register and opcode codes for the roulette breeding engine
// no dependencies
`default_nettype none

package rcm_pkg;

    localparam int VAL_W  = 32;
    localparam int DRAW_W = 16;
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        OP_SCORE  = 2'd0,
        OP_GENE   = 2'd1,
        OP_SELECT = 2'd2,
        OP_CHILD  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_THRESH = 2'd1,
        REG_LRATE  = 2'd2,
        REG_NONE   = 2'd3
    } t_reg;

    typedef struct packed {
        logic capture;
        logic sel_init;
        logic clr_wr;
        logic wr;
        logic rd_en;
        logic rd_scan;
        logic mul;
        logic gene_rd;
        logic step;
        logic pick;
        logic emit;
    } t_cmd;

    // floor(p / 65535) by folding the high part back onto the low part
    function automatic logic [31:0] div_65535(input logic [47:0] p);
        logic [32:0] s1;
        logic [17:0] s2;
        logic [1:0]  e;
        s1 = {1'b0, p[47:16]} + {17'd0, p[15:0]};
        s2 = {1'b0, s1[32:16]} + {2'd0, s1[15:0]};
        if (s2 >= 18'd131070) begin
            e = 2'd2;
        end else if (s2 >= 18'd65535) begin
            e = 2'd1;
        end else begin
            e = 2'd0;
        end
        return 32'(p[47:16] + {15'd0, s1[32:16]} + {30'd0, e});
    endfunction

endpackage

`default_nettype wire

>>> sv/rcm_cfg.sv
// configuration registers behind the apb-style port
// depends on rcm_pkg
`default_nettype none

module rcm_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rcm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output logic      [6:0]                 o_active,
    output logic      [15:0]                o_thresh,
    output logic      [31:0]                o_lrate
);
    import rcm_pkg::*;

    logic [6:0]  r_active;
    logic [15:0] r_thresh;
    logic [31:0] r_lrate;
    t_reg        sel;

    assign sel    = t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 7'd64;
            r_thresh <= 16'd0;
            r_lrate  <= 32'd65536;
        end else if (psel && penable && pwrite) begin
            case (sel)
                REG_ACTIVE: r_active <= pwdata[6:0];
                REG_THRESH: r_thresh <= pwdata[15:0];
                REG_LRATE:  r_lrate  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_ACTIVE: prdata = {25'd0, r_active};
            REG_THRESH: prdata = {16'd0, r_thresh};
            REG_LRATE:  prdata = r_lrate;
            default:    prdata = 32'd0;
        endcase
    end

    assign o_active = r_active;
    assign o_thresh = r_thresh;
    assign o_lrate  = r_lrate;

endmodule

`default_nettype wire

>>> sv/rcm_ctrl.sv
// sequencer: clearing pass, score sum, roulette scan, gene and load steps
// depends on rcm_pkg
`default_nettype none

module rcm_ctrl #(
    parameter int POPULATION = 64,
    parameter int ORG_W      = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [6:0]  i_active,
    output logic             o_busy,
    output rcm_pkg::t_cmd    o_cmd,
    output logic [ORG_W-1:0] o_idx,
    output logic [ORG_W-1:0] o_last
);
    import rcm_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_WRITE, S_SUM, S_SUMW, S_MUL, S_SCAN,
        S_DR1, S_DR2, S_PICK, S_GRD, S_GQ, S_GOUT
    } t_state;

    t_state           r_state, n_state;
    logic [ORG_W-1:0] r_idx, n_idx;
    logic             r_busy;
    logic             accept;

    always_comb begin
        if (i_active == 7'd0) begin
            o_last = '0;
        end else if (32'(i_active) > POPULATION) begin
            o_last = ORG_W'(POPULATION - 1);
        end else begin
            o_last = ORG_W'(32'(i_active) - 32'd1);
        end
    end

    assign accept = (r_state == S_IDLE) && i_start;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_CLR: begin
                n_idx = r_idx + 1'b1;
                if (32'(r_idx) == POPULATION - 1) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_idx = '0;
                    case (t_op'(i_opcode))
                        OP_SELECT: n_state = S_SUM;
                        OP_CHILD:  n_state = S_GRD;
                        default:   n_state = S_WRITE;
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_SUM: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == o_last) begin
                    n_state = S_SUMW;
                    n_idx   = '0;
                end
            end
            S_SUMW: n_state = S_MUL;
            S_MUL:  n_state = S_SCAN;
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == o_last) begin
                    n_state = S_DR1;
                    n_idx   = '0;
                end
            end
            S_DR1:  n_state = S_DR2;
            S_DR2:  n_state = S_PICK;
            S_PICK: n_state = S_IDLE;
            S_GRD:  n_state = S_GQ;
            S_GQ:   n_state = S_GOUT;
            S_GOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.sel_init = accept && (t_op'(i_opcode) == OP_SELECT);
        o_cmd.clr_wr   = (r_state == S_CLR);
        o_cmd.wr       = (r_state == S_WRITE);
        o_cmd.rd_en    = (r_state == S_SUM) || (r_state == S_SCAN);
        o_cmd.rd_scan  = (r_state == S_SCAN);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.gene_rd  = (r_state == S_GRD);
        o_cmd.step     = (r_state == S_GQ);
        o_cmd.pick     = (r_state == S_PICK);
        o_cmd.emit     = (r_state == S_WRITE) || (r_state == S_PICK) || (r_state == S_GOUT);
    end

    assign o_busy = r_busy;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

>>> sv/rcm_dp.sv
// datapath: score and gene memories, roulette accumulator, mutation and result word
// depends on rcm_pkg
`default_nettype none

module rcm_dp #(
    parameter int POPULATION = 64,
    parameter int GENE_COUNT = 256,
    parameter int ORG_W      = 6,
    parameter int GA_W       = 14,
    parameter int TOT_W      = 38,
    parameter int ACC_W      = 60
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rcm_pkg::t_cmd      i_cmd,
    input  wire logic [ORG_W-1:0]   i_idx,
    input  wire logic [ORG_W-1:0]   i_last,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [5:0]         i_organism,
    input  wire logic [7:0]         i_gene_index,
    input  wire logic signed [31:0] i_value,
    input  wire logic [15:0]        i_draw_first,
    input  wire logic [15:0]        i_draw_second,
    input  wire logic               i_coin,
    input  wire logic [15:0]        i_mutate_draw,
    input  wire logic               i_step_sign,
    input  wire logic [15:0]        i_step_draw,
    input  wire logic [15:0]        i_thresh,
    input  wire logic [31:0]        i_lrate,
    output logic                    o_valid,
    output logic [1:0]              o_kind,
    output logic [5:0]              o_parent_first,
    output logic [5:0]              o_parent_second,
    output logic signed [31:0]      o_gene_value
);
    import rcm_pkg::*;

    logic [1:0]  r_op;
    logic [5:0]  r_org;
    logic [7:0]  r_gi;
    logic [31:0] r_val;
    logic [15:0] r_d1, r_d2, r_mdraw, r_sdraw;
    logic        r_coin, r_sign;

    logic [31:0] r_score_mem [POPULATION];
    logic [31:0] r_gene_mem  [POPULATION*GENE_COUNT];

    logic [31:0]      r_sd;
    logic             r_sd_vld, r_sd_scan;
    logic [ORG_W-1:0] r_sd_idx;
    logic [TOT_W-1:0] r_total;
    logic [ACC_W-1:0] r_tgt1, r_tgt2, r_acc, acc_n;
    logic [TOT_W+15:0] r_term, m1, m2, term_n;
    logic [TOT_W-1:0] diff;
    logic             r_term_vld;
    logic [ORG_W-1:0] r_term_idx;
    logic             r_found1, r_found2;
    logic [ORG_W-1:0] r_cand1, r_cand2, r_chosen1, r_chosen2, n_chosen1, n_chosen2;
    logic [ORG_W-1:0] parent;
    logic [GA_W-1:0]  wr_addr, rd_addr;
    logic             org_ok, gi_ok, mut;
    logic [31:0]      r_gene_q, r_step;
    logic [47:0]      r_prod;
    logic signed [33:0] gx, sx, gsum;
    logic [31:0]      sat, child;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [5:0]  r_pf, r_ps;
    logic [31:0] r_gene;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_org   <= i_organism;
            r_gi    <= i_gene_index;
            r_val   <= i_value;
            r_d1    <= i_draw_first;
            r_d2    <= i_draw_second;
            r_coin  <= i_coin;
            r_mdraw <= i_mutate_draw;
            r_sign  <= i_step_sign;
            r_sdraw <= i_step_draw;
        end
    end

    assign org_ok  = 32'(r_org) < POPULATION;
    assign gi_ok   = 32'(r_gi) < GENE_COUNT;
    assign parent  = r_coin ? r_chosen2 : r_chosen1;
    assign wr_addr = GA_W'(32'(r_org) * GENE_COUNT + 32'(r_gi));
    assign rd_addr = GA_W'(32'(parent) * GENE_COUNT + 32'(r_gi));

    // score memory, cleared by a pass after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_score_mem[i_idx] <= 32'd0;
        end else if (i_cmd.wr && t_op'(r_op) == OP_SCORE && org_ok) begin
            r_score_mem[ORG_W'(r_org)] <= r_val[31] ? 32'd0 : r_val;
        end
        if (i_cmd.rd_en) begin
            r_sd <= r_score_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && t_op'(r_op) == OP_GENE && org_ok && gi_ok) begin
            r_gene_mem[wr_addr] <= r_val;
        end
        if (i_cmd.gene_rd) begin
            r_gene_q <= r_gene_mem[rd_addr];
        end
    end

    assign m1     = (TOT_W+16)'(r_total) * (TOT_W+16)'(r_d1);
    assign m2     = (TOT_W+16)'(r_total) * (TOT_W+16)'(r_d2);
    assign diff   = r_total - TOT_W'(r_sd);
    assign term_n = {diff, 16'd0} - (TOT_W+16)'(diff);
    assign acc_n  = r_acc + ACC_W'(r_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_vld   <= 1'b0;
            r_sd_scan  <= 1'b0;
            r_term_vld <= 1'b0;
            r_found1   <= 1'b0;
            r_found2   <= 1'b0;
            r_chosen1  <= '0;
            r_chosen2  <= '0;
            r_total    <= '0;
        end else begin
            r_sd_vld   <= i_cmd.rd_en;
            r_sd_scan  <= i_cmd.rd_scan;
            r_term_vld <= r_sd_vld && r_sd_scan;
            if (i_cmd.sel_init) begin
                r_total  <= '0;
                r_found1 <= 1'b0;
                r_found2 <= 1'b0;
            end else begin
                if (r_sd_vld && !r_sd_scan) begin
                    r_total <= r_total + TOT_W'(r_sd);
                end
                if (r_term_vld && !r_found1 && acc_n >= r_tgt1) begin
                    r_found1 <= 1'b1;
                end
                if (r_term_vld && !r_found2 && acc_n >= r_tgt2) begin
                    r_found2 <= 1'b1;
                end
            end
            r_chosen1 <= n_chosen1;
            r_chosen2 <= n_chosen2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd_idx   <= i_idx;
        r_term     <= term_n;
        r_term_idx <= r_sd_idx;
        if (i_cmd.sel_init) begin
            r_acc <= '0;
        end else if (r_term_vld) begin
            r_acc <= acc_n;
        end
        if (r_term_vld && !r_found1) begin
            r_cand1 <= r_term_idx;
        end
        if (r_term_vld && !r_found2) begin
            r_cand2 <= r_term_idx;
        end
        if (i_cmd.mul) begin
            r_tgt1 <= ACC_W'({m1, 1'b0});
            r_tgt2 <= ACC_W'({m2, 1'b0});
        end
        r_prod <= 48'(r_sdraw) * 48'(i_lrate);
        if (i_cmd.step) begin
            r_step <= div_65535(r_prod);
        end
    end

    assign n_chosen1 = i_cmd.pick ? (r_found1 ? r_cand1 : i_last) : r_chosen1;
    assign n_chosen2 = i_cmd.pick ? (r_found2 ? r_cand2 : i_last) : r_chosen2;

    assign mut  = r_mdraw <= i_thresh;
    assign gx   = 34'(signed'(r_gene_q));
    assign sx   = signed'({2'b00, r_step});
    assign gsum = r_sign ? gx - sx : gx + sx;

    always_comb begin
        if (gsum > 34'sd2147483647) begin
            sat = 32'h7FFF_FFFF;
        end else if (gsum < -34'sd2147483648) begin
            sat = 32'h8000_0000;
        end else begin
            sat = gsum[31:0];
        end
        if (!gi_ok) begin
            child = 32'd0;
        end else if (mut) begin
            child = sat;
        end else begin
            child = r_gene_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_kind <= r_op;
            r_pf   <= 6'(n_chosen1);
            r_ps   <= 6'(n_chosen2);
            r_gene <= (t_op'(r_op) == OP_CHILD) ? child : 32'd0;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_parent_first  = r_pf;
    assign o_parent_second = r_ps;
    assign o_gene_value    = r_gene;

endmodule

`default_nettype wire

>>> sv/roulette_crossover_mutation_top.sv
// top level of the roulette breeding engine: config port, sequencer, datapath
// depends on rcm_pkg, rcm_cfg, rcm_ctrl, rcm_dp
`default_nettype none

// A word is taken when start is high and busy is low; one result word follows
// on o_valid for one cycle and cannot be held off. Busy stays high while a score
// or gene load is written, while a child gene passes memory read, step divide and
// add and clamp, and while a parent selection runs, which takes longer with more
// active organisms since the score memory's single read port is walked once to sum
// and once to scan. After reset the score memory is cleared with busy high.
module roulette_crossover_mutation_top #(
    parameter int POPULATION = 64,
    parameter int GENE_COUNT = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [5:0]                 i_organism,
    input  wire logic [7:0]                 i_gene_index,
    input  wire logic signed [31:0]         i_value,
    input  wire logic [15:0]                i_draw_first,
    input  wire logic [15:0]                i_draw_second,
    input  wire logic                       i_coin,
    input  wire logic [15:0]                i_mutate_draw,
    input  wire logic                       i_step_sign,
    input  wire logic [15:0]                i_step_draw,
    output logic                            o_valid,
    output logic [1:0]                      o_kind,
    output logic [5:0]                      o_parent_first,
    output logic [5:0]                      o_parent_second,
    output logic signed [31:0]              o_gene_value,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rcm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import rcm_pkg::*;

    localparam int ORG_W = $clog2(POPULATION);
    localparam int GA_W  = $clog2(POPULATION * GENE_COUNT);
    localparam int TOT_W = 32 + ORG_W;
    localparam int ACC_W = TOT_W + 16 + ORG_W;

    logic [6:0]       active;
    logic [15:0]      thresh;
    logic [31:0]      lrate;
    t_cmd             cmd;
    logic [ORG_W-1:0] idx, last;

    rcm_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_active (active),
        .o_thresh (thresh),
        .o_lrate  (lrate)
    );

    rcm_ctrl #(.POPULATION(POPULATION), .ORG_W(ORG_W)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_active (active),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .o_idx    (idx),
        .o_last   (last)
    );

    rcm_dp #(
        .POPULATION (POPULATION),
        .GENE_COUNT (GENE_COUNT),
        .ORG_W      (ORG_W),
        .GA_W       (GA_W),
        .TOT_W      (TOT_W),
        .ACC_W      (ACC_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .i_last          (last),
        .i_opcode        (i_opcode),
        .i_organism      (i_organism),
        .i_gene_index    (i_gene_index),
        .i_value         (i_value),
        .i_draw_first    (i_draw_first),
        .i_draw_second   (i_draw_second),
        .i_coin          (i_coin),
        .i_mutate_draw   (i_mutate_draw),
        .i_step_sign     (i_step_sign),
        .i_step_draw     (i_step_draw),
        .i_thresh        (thresh),
        .i_lrate         (lrate),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_parent_first  (o_parent_first),
        .o_parent_second (o_parent_second),
        .o_gene_value    (o_gene_value)
    );

endmodule

`default_nettype wire

>>> sv/rcm_check.sv
// port-level checks on the breeding engine, bound to the top level
// depends on rcm_pkg and roulette_crossover_mutation_top
`default_nettype none

module rcm_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [1:0]  o_kind,
    input wire logic [31:0] o_gene_value
);
    import rcm_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_gene_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != OP_CHILD |-> o_gene_value == 32'd0)
        else $error("gene value nonzero on non-child result");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

bind roulette_crossover_mutation_top rcm_check u_rcm_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_kind       (o_kind),
    .o_gene_value (o_gene_value)
);

`default_nettype wire
